FILE: hw/rtl/bed_pkg.sv
`timescale 1ns / 1ps
// Package for the backslash escape decoder: result types, character codes
// and the hex digit helper. No dependencies.
package bed_pkg;

    localparam int BYTE_W = 8;

    // Character codes that the decoder looks for or produces.
    localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;
    localparam logic [BYTE_W-1:0] CH_N      = 8'h6E;
    localparam logic [BYTE_W-1:0] CH_T      = 8'h74;
    localparam logic [BYTE_W-1:0] CH_R      = 8'h72;
    localparam logic [BYTE_W-1:0] CH_A      = 8'h61;
    localparam logic [BYTE_W-1:0] CH_B      = 8'h62;
    localparam logic [BYTE_W-1:0] CH_X_LO   = 8'h78;
    localparam logic [BYTE_W-1:0] CH_X_UP   = 8'h58;
    localparam logic [BYTE_W-1:0] CH_ZERO   = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE   = 8'h39;
    localparam logic [BYTE_W-1:0] CH_LC_A   = 8'h61;
    localparam logic [BYTE_W-1:0] CH_LC_F   = 8'h66;
    localparam logic [BYTE_W-1:0] CH_UC_A   = 8'h41;
    localparam logic [BYTE_W-1:0] CH_UC_F   = 8'h46;
    localparam logic [BYTE_W-1:0] VAL_LF    = 8'd10;
    localparam logic [BYTE_W-1:0] VAL_TAB   = 8'd9;
    localparam logic [BYTE_W-1:0] VAL_CR    = 8'd13;
    localparam logic [BYTE_W-1:0] VAL_BEL   = 8'd7;
    localparam logic [BYTE_W-1:0] VAL_BS    = 8'd8;

    localparam logic [1:0] OCT_DIGITS_MAX = 2'd3;
    localparam logic [1:0] HEX_DIGITS_MAX = 2'd2;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              byte_valid;
        logic              end_of_string;
    } t_result;

    // Up to two results produced by one input word.
    typedef struct packed {
        logic [1:0] cnt;
        t_result    res0;
        t_result    res1;
    } t_pair;

    function automatic t_result mk_result(input logic [BYTE_W-1:0] b);
        t_result r;
        r.out_byte      = b;
        r.byte_valid    = 1'b1;
        r.end_of_string = 1'b0;
        return r;
    endfunction

    // Returns {digit_ok, value}.
    function automatic logic [4:0] hex_value(input logic [BYTE_W-1:0] b);
        logic [4:0] v;
        v = 5'd0;
        if (b >= CH_ZERO && b <= CH_NINE) begin
            v = {1'b1, 4'(b - CH_ZERO)};
        end else if (b >= CH_LC_A && b <= CH_LC_F) begin
            v = {1'b1, 4'(b - CH_LC_A + 8'd10)};
        end else if (b >= CH_UC_A && b <= CH_UC_F) begin
            v = {1'b1, 4'(b - CH_UC_A + 8'd10)};
        end
        return v;
    endfunction

endpackage

FILE: hw/rtl/bed_in_if.sv
`timescale 1ns / 1ps
// Input channel of the backslash escape decoder: one string character a word.
// Depends on bed_pkg.
interface bed_in_if;
    logic                      valid;
    logic                      ready;
    logic [bed_pkg::BYTE_W-1:0] in_byte;
    logic                      in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

FILE: hw/rtl/bed_out_if.sv
`timescale 1ns / 1ps
// Output channel of the backslash escape decoder: one decoded character a word.
// Depends on bed_pkg.
interface bed_out_if;
    logic                      valid;
    logic                      ready;
    logic [bed_pkg::BYTE_W-1:0] out_byte;
    logic                      byte_valid;
    logic                      end_of_string;

    modport source (output valid, output out_byte, output byte_valid,
                    output end_of_string, input ready);
    modport sink   (input valid, input out_byte, input byte_valid,
                    input end_of_string, output ready);
endinterface

FILE: hw/rtl/backslash_escape_decoder.sv
`timescale 1ns / 1ps
// Backslash escape decoder. A string comes in one character a word, with a
// last flag on its final character; decoded characters leave one a word, the
// final result of each string flagged, and a string whose final character
// yields nothing ends with a bare end marker (byte_valid low). Each accepted
// character is decoded in the cycle it is taken and its results appear at the
// output in the cycle after. A character yields zero, one or two results; the
// two-slot output register drains one result a cycle while the output is
// ready, and input is taken every cycle while it is and each character yields
// at most one result; one that yields two holds input until one result leaves.
// Depends on bed_pkg, bed_in_if, bed_out_if, bed_decode and bed_out_buf.
module backslash_escape_decoder (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bed_in_if.sink    i_in_ch,
    bed_out_if.source o_out_ch
);
    import bed_pkg::*;

    logic  w_ready;
    logic  w_accept;
    t_pair w_pair;

    assign i_in_ch.ready = w_ready;
    assign w_accept      = i_in_ch.valid && w_ready;

    bed_decode u_decode (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (w_accept),
        .i_in_byte (i_in_ch.in_byte),
        .i_in_last (i_in_ch.in_last),
        .o_pair    (w_pair)
    );

    bed_out_buf u_out_buf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_accept),
        .i_pair   (w_pair),
        .o_ready  (w_ready),
        .o_out_ch (o_out_ch)
    );

endmodule

FILE: hw/rtl/bed_decode.sv
`timescale 1ns / 1ps
// Escape decode state and the single-pass logic that turns one input word
// into zero, one or two results. Depends on bed_pkg.
module bed_decode (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_accept,
    input  logic [bed_pkg::BYTE_W-1:0] i_in_byte,
    input  logic                       i_in_last,
    output bed_pkg::t_pair             o_pair
);
    import bed_pkg::*;

    localparam logic [1:0] MODE_NORMAL = 2'd0;
    localparam logic [1:0] MODE_ESCAPE = 2'd1;
    localparam logic [1:0] MODE_OCTAL  = 2'd2;
    localparam logic [1:0] MODE_HEX    = 2'd3;

    logic [1:0]        r_mode, n_mode;
    logic [BYTE_W-1:0] r_acc, n_acc;
    logic [1:0]        r_dcnt, n_dcnt;

    logic              w_is_oct;
    logic [4:0]        w_hex;
    logic [1:0]        w_dcnt_inc;
    logic [BYTE_W-1:0] w_acc_oct;
    logic [BYTE_W-1:0] w_acc_hex;
    t_pair             w_pair;

    assign w_is_oct   = (i_in_byte[7:3] == 5'b00110);
    assign w_hex      = hex_value(i_in_byte);
    assign w_dcnt_inc = r_dcnt + 2'd1;
    assign w_acc_oct  = {r_acc[4:0], i_in_byte[2:0]};
    assign w_acc_hex  = {r_acc[3:0], w_hex[3:0]};

    always_comb begin
        n_mode = r_mode;
        n_acc  = r_acc;
        n_dcnt = r_dcnt;
        w_pair = '0;

        case (r_mode)
            MODE_ESCAPE: begin
                n_mode = MODE_NORMAL;
                if (i_in_byte == CH_BSLASH) begin
                    w_pair.res0 = mk_result(CH_BSLASH);
                    w_pair.res1 = mk_result(CH_BSLASH);
                    w_pair.cnt  = 2'd2;
                end else if (i_in_byte == CH_N) begin
                    w_pair.res0 = mk_result(VAL_LF);
                    w_pair.cnt  = 2'd1;
                end else if (i_in_byte == CH_T) begin
                    w_pair.res0 = mk_result(VAL_TAB);
                    w_pair.cnt  = 2'd1;
                end else if (i_in_byte == CH_R) begin
                    w_pair.res0 = mk_result(VAL_CR);
                    w_pair.cnt  = 2'd1;
                end else if (i_in_byte == CH_A) begin
                    w_pair.res0 = mk_result(VAL_BEL);
                    w_pair.cnt  = 2'd1;
                end else if (i_in_byte == CH_B) begin
                    w_pair.res0 = mk_result(VAL_BS);
                    w_pair.cnt  = 2'd1;
                end else if (w_is_oct) begin
                    n_mode = MODE_OCTAL;
                    n_acc  = {5'd0, i_in_byte[2:0]};
                    n_dcnt = 2'd1;
                end else if (i_in_byte == CH_X_LO || i_in_byte == CH_X_UP) begin
                    n_mode = MODE_HEX;
                    n_acc  = '0;
                    n_dcnt = 2'd0;
                end else begin
                    w_pair.res0 = mk_result(i_in_byte);
                    w_pair.cnt  = 2'd1;
                end
            end
            MODE_OCTAL, MODE_HEX: begin
                if ((r_mode == MODE_OCTAL) ? w_is_oct : w_hex[4]) begin
                    n_acc  = (r_mode == MODE_OCTAL) ? w_acc_oct : w_acc_hex;
                    n_dcnt = w_dcnt_inc;
                    if (w_dcnt_inc >= ((r_mode == MODE_OCTAL) ? OCT_DIGITS_MAX
                                                              : HEX_DIGITS_MAX)) begin
                        w_pair.res0 = mk_result(n_acc);
                        w_pair.cnt  = 2'd1;
                        n_mode      = MODE_NORMAL;
                        n_acc       = '0;
                        n_dcnt      = 2'd0;
                    end
                end else begin
                    // The pending value goes out first, then the byte is
                    // taken as plain text.
                    w_pair.res0 = mk_result(r_acc);
                    w_pair.cnt  = 2'd1;
                    n_acc       = '0;
                    n_dcnt      = 2'd0;
                    if (i_in_byte == CH_BSLASH) begin
                        n_mode = MODE_ESCAPE;
                    end else begin
                        n_mode      = MODE_NORMAL;
                        w_pair.res1 = mk_result(i_in_byte);
                        w_pair.cnt  = 2'd2;
                    end
                end
            end
            default: begin
                if (i_in_byte == CH_BSLASH) begin
                    n_mode = MODE_ESCAPE;
                end else begin
                    w_pair.res0 = mk_result(i_in_byte);
                    w_pair.cnt  = 2'd1;
                end
            end
        endcase

        if (i_in_last) begin
            // A number is still open only if this word emitted nothing.
            if (n_mode == MODE_OCTAL || n_mode == MODE_HEX) begin
                w_pair.res0 = mk_result(n_acc);
                w_pair.cnt  = 2'd1;
            end
            if (w_pair.cnt == 2'd0) begin
                w_pair.res0.out_byte      = '0;
                w_pair.res0.byte_valid    = 1'b0;
                w_pair.res0.end_of_string = 1'b1;
                w_pair.cnt                = 2'd1;
            end else if (w_pair.cnt == 2'd1) begin
                w_pair.res0.end_of_string = 1'b1;
            end else begin
                w_pair.res1.end_of_string = 1'b1;
            end
            n_mode = MODE_NORMAL;
            n_acc  = '0;
            n_dcnt = 2'd0;
        end
    end

    assign o_pair = w_pair;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_NORMAL;
            r_acc  <= '0;
            r_dcnt <= 2'd0;
        end else if (i_accept) begin
            r_mode <= n_mode;
            r_acc  <= n_acc;
            r_dcnt <= n_dcnt;
        end
    end

endmodule

FILE: hw/rtl/bed_out_buf.sv
`timescale 1ns / 1ps
// Two-slot result register that hands the results of one input word out
// one word at a time. Depends on bed_pkg and bed_out_if.
module bed_out_buf (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_load,
    input  bed_pkg::t_pair i_pair,
    output logic           o_ready,
    bed_out_if.source      o_out_ch
);
    import bed_pkg::*;

    logic [1:0] r_cnt, n_cnt;
    t_result    r_slot0, n_slot0;
    t_result    r_slot1, n_slot1;
    logic       w_take;

    assign w_take = (r_cnt != 2'd0) && o_out_ch.ready;
    // A new pair may land when the slots are empty or the last one leaves now.
    assign o_ready = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && o_out_ch.ready);

    always_comb begin
        n_cnt   = r_cnt;
        n_slot0 = r_slot0;
        n_slot1 = r_slot1;
        if (i_load) begin
            n_cnt   = i_pair.cnt;
            n_slot0 = i_pair.res0;
            n_slot1 = i_pair.res1;
        end else if (w_take) begin
            n_cnt   = r_cnt - 2'd1;
            n_slot0 = r_slot1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot0 <= n_slot0;
        r_slot1 <= n_slot1;
    end

    assign o_out_ch.valid         = (r_cnt != 2'd0);
    assign o_out_ch.out_byte      = r_slot0.out_byte;
    assign o_out_ch.byte_valid    = r_slot0.byte_valid;
    assign o_out_ch.end_of_string = r_slot0.end_of_string;

endmodule

FILE: tb/backslash_escape_decoder_checker.sv
`timescale 1ns / 1ps
// Checker for the backslash escape decoder: watches both channels, predicts the
// decoded words of every accepted character and compares them in order.
// Depends on bed_pkg, bed_in_if and bed_out_if.
module backslash_escape_decoder_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    bed_in_if    i_in_mon,
    bed_out_if   i_out_mon,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_words_checked,
    output int   o_markers
);
    import bed_pkg::*;

    typedef enum logic [1:0] {
        DM_NORMAL,
        DM_ESCAPE,
        DM_OCTAL,
        DM_HEX
    } t_mode;

    localparam logic [BYTE_W-1:0] CH_SEVEN = CH_ZERO + 8'd7;

    t_mode             mode = DM_NORMAL;
    logic [BYTE_W-1:0] accum = '0;
    logic [1:0]        ndigits = '0;

    t_result step_words[$];
    t_result decoded_q[$];

    int fail_cnt = 0;
    int checked_cnt = 0;
    int marker_cnt = 0;

    assign o_fail_count    = fail_cnt;
    assign o_pending       = decoded_q.size();
    assign o_words_checked = checked_cnt;
    assign o_markers       = marker_cnt;

    function automatic void push_char(input logic [BYTE_W-1:0] b);
        t_result r;
        r.out_byte      = b;
        r.byte_valid    = 1'b1;
        r.end_of_string = 1'b0;
        step_words.push_back(r);
    endfunction

    function automatic void plain_char(input logic [BYTE_W-1:0] b);
        if (b == CH_BSLASH) begin
            mode = DM_ESCAPE;
        end else begin
            push_char(b);
        end
    endfunction

    function automatic void flush_value();
        push_char(accum);
        mode    = DM_NORMAL;
        accum   = '0;
        ndigits = '0;
    endfunction

    // Returns {is_digit, value} for a hex digit of either case.
    function automatic logic [4:0] hex_digit(input logic [BYTE_W-1:0] b);
        if (b >= CH_ZERO && b <= CH_NINE) begin
            return {1'b1, b[3:0]};
        end else if ((b >= CH_LC_A && b <= CH_LC_F) || (b >= CH_UC_A && b <= CH_UC_F)) begin
            return {1'b1, b[3:0] + 4'd9};
        end
        return 5'd0;
    endfunction

    task automatic decode_char(input logic [BYTE_W-1:0] b, input logic last);
        logic [4:0] hd;
        t_result    r;
        case (mode)
            DM_ESCAPE: begin
                mode = DM_NORMAL;
                if (b == CH_BSLASH) begin
                    push_char(CH_BSLASH);
                    push_char(CH_BSLASH);
                end else if (b == CH_N) begin
                    push_char(VAL_LF);
                end else if (b == CH_T) begin
                    push_char(VAL_TAB);
                end else if (b == CH_R) begin
                    push_char(VAL_CR);
                end else if (b == CH_A) begin
                    push_char(VAL_BEL);
                end else if (b == CH_B) begin
                    push_char(VAL_BS);
                end else if (b >= CH_ZERO && b <= CH_SEVEN) begin
                    mode    = DM_OCTAL;
                    accum   = {5'd0, b[2:0]};
                    ndigits = 2'd1;
                end else if (b == CH_X_LO || b == CH_X_UP) begin
                    mode    = DM_HEX;
                    accum   = '0;
                    ndigits = '0;
                end else begin
                    push_char(b);
                end
            end
            DM_OCTAL: begin
                if (b >= CH_ZERO && b <= CH_SEVEN) begin
                    // The value wraps to eight bits as digits shift in.
                    accum   = {accum[4:0], b[2:0]};
                    ndigits = ndigits + 2'd1;
                    if (ndigits == OCT_DIGITS_MAX) flush_value();
                end else begin
                    flush_value();
                    plain_char(b);
                end
            end
            DM_HEX: begin
                hd = hex_digit(b);
                if (hd[4]) begin
                    accum   = {accum[3:0], hd[3:0]};
                    ndigits = ndigits + 2'd1;
                    if (ndigits == HEX_DIGITS_MAX) flush_value();
                end else begin
                    flush_value();
                    plain_char(b);
                end
            end
            default: begin
                plain_char(b);
            end
        endcase

        if (last) begin
            if (mode == DM_OCTAL || mode == DM_HEX) flush_value();
            if (step_words.size() == 0) begin
                r.out_byte      = '0;
                r.byte_valid    = 1'b0;
                r.end_of_string = 1'b1;
            end else begin
                r = step_words.pop_back();
                r.end_of_string = 1'b1;
            end
            step_words.push_back(r);
            mode    = DM_NORMAL;
            accum   = '0;
            ndigits = '0;
        end

        foreach (step_words[i]) decoded_q.push_back(step_words[i]);
        step_words.delete();
    endtask

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n) begin
            if (i_in_mon.valid && i_in_mon.ready) begin
                decode_char(i_in_mon.in_byte, i_in_mon.in_last);
            end
            if (i_out_mon.valid && i_out_mon.ready) begin
                got.out_byte      = i_out_mon.out_byte;
                got.byte_valid    = i_out_mon.byte_valid;
                got.end_of_string = i_out_mon.end_of_string;
                if (decoded_q.size() == 0) begin
                    $display("%0t: unexpected word out_byte %02h byte_valid %b end %b",
                             $time, got.out_byte, got.byte_valid, got.end_of_string);
                    fail_cnt++;
                end else begin
                    want = decoded_q.pop_front();
                    if (got !== want) begin
                        $display({"%0t: mismatch, expected out_byte %02h byte_valid %b",
                                  " end %b, got %02h %b %b"},
                                 $time, want.out_byte, want.byte_valid, want.end_of_string,
                                 got.out_byte, got.byte_valid, got.end_of_string);
                        fail_cnt++;
                    end
                    checked_cnt++;
                    if (!got.byte_valid) marker_cnt++;
                end
            end
        end
    end

endmodule

FILE: tb/backslash_escape_decoder_tb.sv
`timescale 1ns / 1ps
// Top of the backslash escape decoder testbench: clock, reset, directed and
// random strings, input gaps, output stalls and the verdict.
// Depends on bed_pkg, bed_in_if, bed_out_if, backslash_escape_decoder and backslash_escape_decoder_checker.
module backslash_escape_decoder_tb;
    import bed_pkg::*;

    localparam int RANDOM_CHARS = 1200;
    localparam int LONG_HOLD    = 48;

    logic i_clk;
    logic i_rst_n;

    bed_in_if  in_ch ();
    bed_out_if out_ch ();

    int fail_count;
    int pending;
    int words_checked;
    int markers;

    backslash_escape_decoder dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in_ch  (in_ch),
        .o_out_ch (out_ch)
    );

    backslash_escape_decoder_checker checker_i (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_mon        (in_ch),
        .i_out_mon       (out_ch),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_words_checked (words_checked),
        .o_markers       (markers)
    );

    bit idle_en = 1'b1;
    bit quiet = 1'b0;
    bit hold_req = 1'b0;
    int chars_sent = 0;
    int strings_sent = 0;

    logic [BYTE_W-1:0] text_q[$];
    string hex_chars = "0123456789abcdefABCDEF";
    logic [BYTE_W-1:0] simple_esc [6] = '{CH_BSLASH, CH_N, CH_T, CH_R, CH_A, CH_B};

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    initial begin
        #2000000;
        $display("backslash_escape_decoder_tb failed");
        $finish;
    end

    // Output side: random short stalls, and one long hold-off on request.
    initial begin
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                out_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else if (idle_en && !quiet && $urandom_range(0, 5) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge i_clk);
            end else begin
                out_ch.ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    task automatic put_word(input logic [BYTE_W-1:0] b, input logic last);
        int gap;
        gap = 0;
        if (idle_en && !quiet && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 3);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.in_byte <= b;
        in_ch.in_last <= last;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        chars_sent++;
    endtask

    task automatic send_text();
        foreach (text_q[i]) put_word(text_q[i], i == text_q.size() - 1);
        strings_sent++;
    endtask

    task automatic send_literal(input string s);
        text_q.delete();
        for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
        send_text();
    endtask

    // Stops offering words and waits until every decoded word has come out.
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic void add_token();
        int k;
        k = $urandom_range(0, 15);
        case (k)
            0, 1, 2, 3: begin
                text_q.push_back(8'($urandom_range(1, 255)));
            end
            4, 5: begin
                text_q.push_back(CH_BSLASH);
                text_q.push_back(simple_esc[$urandom_range(0, 5)]);
            end
            6, 7, 8: begin
                text_q.push_back(CH_BSLASH);
                repeat ($urandom_range(1, 4)) text_q.push_back(CH_ZERO + 8'($urandom_range(0, 7)));
            end
            9, 10, 11: begin
                text_q.push_back(CH_BSLASH);
                text_q.push_back($urandom_range(0, 1) ? CH_X_LO : CH_X_UP);
                repeat ($urandom_range(0, 3)) text_q.push_back(hex_chars[$urandom_range(0, 21)]);
            end
            12: begin
                text_q.push_back(CH_BSLASH);
                text_q.push_back(8'($urandom_range(1, 255)));
            end
            default: begin
                text_q.push_back(8'($urandom_range(8'h20, 8'h7E)));
            end
        endcase
    endfunction

    initial begin
        int base;
        bit pressed;
        in_ch.valid   <= 1'b0;
        in_ch.in_byte <= '0;
        in_ch.in_last <= 1'b0;
        i_rst_n       <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Byte extremes around a double backslash.
        text_q.delete();
        text_q.push_back(8'h01);
        text_q.push_back(CH_BSLASH);
        text_q.push_back(CH_BSLASH);
        text_q.push_back(8'hFF);
        send_text();
        send_literal("\\n\\t\\r\\a\\b");
        // Full octal and hex digit counts; the octal value wraps.
        send_literal("\\777\\XaB");
        // A lone trailing backslash leaves only a bare end marker.
        send_literal("\\");
        send_literal("\\5");
        // Octal cut short by a letter, then a hex escape with no digits.
        send_literal("\\1g\\x");
        drain();

        base = chars_sent;
        pressed = 1'b0;
        while (chars_sent - base < RANDOM_CHARS) begin
            idle_en = (chars_sent - base) < (RANDOM_CHARS * 17 / 20);
            if (!pressed && chars_sent - base > RANDOM_CHARS / 3) begin
                // Long output stall while input keeps coming, then a full drain.
                pressed = 1'b1;
                quiet = 1'b1;
                hold_req = 1'b1;
                text_q.delete();
                repeat (24) text_q.push_back(8'($urandom_range(8'h20, 8'h7E)));
                send_text();
                drain();
            end
            text_q.delete();
            if ($urandom_range(0, 19) == 0) begin
                text_q.push_back(CH_BSLASH);
            end else begin
                repeat ($urandom_range(1, 5)) add_token();
                if ($urandom_range(0, 9) == 0) text_q.push_back(CH_BSLASH);
            end
            quiet = ($urandom_range(0, 3) == 0);
            send_text();
        end
        drain();

        $display("Sent %0d characters in %0d strings, with random stalls, a long output stall",
                 chars_sent, strings_sent);
        $display("and a full drain; checked %0d decoded words, %0d of them bare end markers.",
                 words_checked, markers);
        if (fail_count == 0) begin
            $display("backslash_escape_decoder_tb passed");
        end else begin
            $display("backslash_escape_decoder_tb failed");
        end
        $finish;
    end

endmodule
